// ===== src/psrm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psrm_pkg
// Shared types and constants for the pivot swap to row move converter.
// ----------------------------------------------------------------------------
package psrm_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int PIVOT_W      = 7;
    localparam int DEST_W       = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIV,
        ST_RDI,
        ST_RDT,
        ST_WRI,
        ST_WRT,
        ST_ORD,
        ST_OLD
    } state_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest_row;
        logic              bad_pivot;
        logic              last_result;
    } result_t;

endpackage
`default_nettype wire

// ===== src/psrm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psrm_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module psrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== src/psrm_conv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psrm_conv
// Loads pivots into a memory, walks them against the destination table
// memory with read-modify-write steps, then reads the table out in order.
// ----------------------------------------------------------------------------
module psrm_conv #(
    parameter int MAX_ROWS = psrm_pkg::MAX_ROWS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [psrm_pkg::PIVOT_W-1:0] in_pivot,
    input  wire logic                         in_last,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output psrm_pkg::result_t                 res
);

    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    psrm_pkg::state_t state_reg, state_next;

    logic                 transpose_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     row_reg, row_next;
    logic [IDX_W-1:0]     t_reg, t_next;
    logic [IDX_W-1:0]     cur_i_reg, cur_i_next;
    logic                 err_reg, err_next;
    logic [MAX_ROWS-1:0]  valid_reg, valid_next;

    logic                 piv_wr_en;
    logic                 piv_rd_en;
    logic [IDX_W-1:0]     piv_rd_addr;
    logic [psrm_pkg::PIVOT_W-1:0] piv_rd_data;
    logic                 dst_wr_en;
    logic [IDX_W-1:0]     dst_wr_addr;
    logic [IDX_W-1:0]     dst_wr_data;
    logic                 dst_rd_en;
    logic [IDX_W-1:0]     dst_rd_addr;
    logic [IDX_W-1:0]     dst_rd_data;

    logic                 accept;
    logic                 full;
    logic [CNT_W-1:0]     cnt_load;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     load_last_idx;
    logic                 last_row;
    logic [IDX_W-1:0]     row_step;
    logic                 bad;
    logic [IDX_W-1:0]     cur_rd;
    logic [IDX_W-1:0]     cur_t;

    assign accept        = in_valid && in_ready;
    assign full          = cnt_reg >= CNT_W'(MAX_ROWS);
    assign cnt_load      = full ? cnt_reg : cnt_reg + CNT_W'(1);
    assign last_idx      = IDX_W'(cnt_reg - CNT_W'(1));
    assign load_last_idx = IDX_W'(cnt_load - CNT_W'(1));
    assign last_row      = transpose_reg ? (row_reg == '0) : (row_reg == last_idx);
    assign row_step      = transpose_reg ? row_reg - IDX_W'(1) : row_reg + IDX_W'(1);
    assign bad           = (piv_rd_data == '0) ||
                           (piv_rd_data > psrm_pkg::PIVOT_W'(cnt_reg));
    assign cur_rd        = valid_reg[row_reg] ? dst_rd_data : row_reg;
    assign cur_t         = valid_reg[t_reg] ? dst_rd_data : t_reg;

    psrm_ram #(
        .WIDTH (psrm_pkg::PIVOT_W),
        .DEPTH (MAX_ROWS)
    ) u_pivot_ram (
        .aclk    (aclk),
        .wr_en   (piv_wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (in_pivot),
        .rd_en   (piv_rd_en),
        .rd_addr (piv_rd_addr),
        .rd_data (piv_rd_data)
    );

    psrm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ROWS)
    ) u_dest_ram (
        .aclk    (aclk),
        .wr_en   (dst_wr_en),
        .wr_addr (dst_wr_addr),
        .wr_data (dst_wr_data),
        .rd_en   (dst_rd_en),
        .rd_addr (dst_rd_addr),
        .rd_data (dst_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psrm_pkg::ST_LOAD: begin
                if (accept && in_last) begin
                    state_next = psrm_pkg::ST_PIV;
                end
            end
            psrm_pkg::ST_PIV: state_next = psrm_pkg::ST_RDI;
            psrm_pkg::ST_RDI: state_next = psrm_pkg::ST_RDT;
            psrm_pkg::ST_RDT: state_next = psrm_pkg::ST_WRI;
            psrm_pkg::ST_WRI: begin
                if (t_reg > row_reg) begin
                    state_next = psrm_pkg::ST_WRT;
                end else if (last_row) begin
                    state_next = psrm_pkg::ST_ORD;
                end else begin
                    state_next = psrm_pkg::ST_RDI;
                end
            end
            psrm_pkg::ST_WRT: begin
                state_next = last_row ? psrm_pkg::ST_ORD : psrm_pkg::ST_RDI;
            end
            psrm_pkg::ST_ORD: state_next = psrm_pkg::ST_OLD;
            psrm_pkg::ST_OLD: begin
                if (res_ready) begin
                    state_next = (row_reg == last_idx) ? psrm_pkg::ST_LOAD
                                                       : psrm_pkg::ST_ORD;
                end
            end
            default: state_next = psrm_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        piv_wr_en   = 1'b0;
        piv_rd_en   = 1'b0;
        piv_rd_addr = row_reg;
        dst_wr_en   = 1'b0;
        dst_wr_addr = row_reg;
        dst_wr_data = cur_t;
        dst_rd_en   = 1'b0;
        dst_rd_addr = row_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        t_next      = t_reg;
        cur_i_next  = cur_i_reg;
        err_next    = err_reg;
        valid_next  = valid_reg;
        case (state_reg)
            psrm_pkg::ST_LOAD: begin
                in_ready = 1'b1;
                if (accept) begin
                    piv_wr_en = !full;
                    cnt_next  = cnt_load;
                    if (in_last) begin
                        valid_next = '0;
                        row_next   = transpose_reg ? load_last_idx : '0;
                    end
                end
            end
            psrm_pkg::ST_PIV: begin
                piv_rd_en = 1'b1;
            end
            psrm_pkg::ST_RDI: begin
                dst_rd_en = 1'b1;
                t_next    = bad ? row_reg : IDX_W'(piv_rd_data - psrm_pkg::PIVOT_W'(1));
                err_next  = err_reg || bad;
            end
            psrm_pkg::ST_RDT: begin
                cur_i_next  = cur_rd;
                dst_rd_en   = 1'b1;
                dst_rd_addr = t_reg;
            end
            psrm_pkg::ST_WRI: begin
                dst_wr_en           = 1'b1;
                valid_next[row_reg] = 1'b1;
                piv_rd_en           = !last_row;
                piv_rd_addr         = row_step;
                if (!(t_reg > row_reg)) begin
                    row_next = last_row ? '0 : row_step;
                end
            end
            psrm_pkg::ST_WRT: begin
                dst_wr_en         = 1'b1;
                dst_wr_addr       = t_reg;
                dst_wr_data       = cur_i_reg;
                valid_next[t_reg] = 1'b1;
                row_next          = last_row ? '0 : row_step;
            end
            psrm_pkg::ST_ORD: begin
                dst_rd_en = 1'b1;
            end
            psrm_pkg::ST_OLD: begin
                res_valid       = 1'b1;
                res.dest_row    = psrm_pkg::DEST_W'(cur_rd);
                res.bad_pivot   = err_reg;
                res.last_result = (row_reg == last_idx);
                if (res_ready) begin
                    if (row_reg == last_idx) begin
                        cnt_next = '0;
                        err_next = 1'b0;
                        row_next = '0;
                    end else begin
                        row_next = row_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= psrm_pkg::ST_LOAD;
            transpose_reg <= 1'b0;
            cnt_reg       <= '0;
            row_reg       <= '0;
            err_reg       <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                transpose_reg <= cfg_wr_data;
            end
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            err_reg   <= err_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg     <= t_next;
        cur_i_reg <= cur_i_next;
    end

`ifndef SYNTHESIS
    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psrm_pkg::ST_RDI || state_reg == psrm_pkg::ST_RDT ||
         state_reg == psrm_pkg::ST_WRI || state_reg == psrm_pkg::ST_WRT ||
         state_reg == psrm_pkg::ST_OLD) |-> (CNT_W'(row_reg) < cnt_reg))
        else $error("Row index is outside the loaded count.");

    a_partner_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psrm_pkg::ST_WRT) |-> (t_reg > row_reg))
        else $error("Partner row write issued for a partner at or below the row.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ROWS))
        else $error("Entry count exceeds the store depth.");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready && res.last_result) |=>
        (state_reg == psrm_pkg::ST_LOAD && cnt_reg == '0 && !err_reg))
        else $error("Run did not return to loading with a cleared count and flag.");
`endif

endmodule
`default_nettype wire

// ===== src/psrm_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psrm_out
// Output register stage that holds one result word until it is taken.
// ----------------------------------------------------------------------------
module psrm_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        res_valid,
    output logic                             res_ready,
    input  wire psrm_pkg::result_t           res,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [psrm_pkg::DEST_W-1:0]      m_dest_row,
    output logic                             m_bad_pivot,
    output logic                             m_last_result
);

    logic              valid_reg;
    psrm_pkg::result_t data_reg;

    assign res_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid       = valid_reg;
    assign m_dest_row    = data_reg.dest_row;
    assign m_bad_pivot   = data_reg.bad_pivot;
    assign m_last_result = data_reg.last_result;

endmodule
`default_nettype wire

// ===== src/pivot_swaps_to_row_moves.sv =====
// Loading accepts one pivot word per cycle while loading; a word without the last mark causes
// no result. After the last word, conversion reads the first pivot, then per row reads the row
// and partner entries and writes the row, plus the partner if it lies above, set by the single
// read port of the destination table. Results are then read from it in order and registered.
// Reset is synchronous and active low; it clears the count, flags, row valid bits and mode.
`default_nettype none
// ----------------------------------------------------------------------------
// pivot_swaps_to_row_moves
// Converts a vector of sequential row-swap pivots into destination rows.
// ----------------------------------------------------------------------------
module pivot_swaps_to_row_moves #(
    parameter int MAX_ROWS = psrm_pkg::MAX_ROWS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [psrm_pkg::PIVOT_W-1:0] s_pivot_row,
    input  wire logic                         s_last_entry,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [psrm_pkg::DEST_W-1:0]       m_dest_row,
    output logic                              m_bad_pivot,
    output logic                              m_last_result
);

    logic              res_valid;
    logic              res_ready;
    psrm_pkg::result_t res;

    psrm_conv #(
        .MAX_ROWS (MAX_ROWS)
    ) u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_pivot    (s_pivot_row),
        .in_last     (s_last_entry),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    psrm_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dest_row    (m_dest_row),
        .m_bad_pivot   (m_bad_pivot),
        .m_last_result (m_last_result)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the pivot swap to row move converter.
// Pivot vectors of many lengths, with good pivots, bad pivots and an overfull
// store, are sent in both walk orders under several idling patterns. A built-in
// model predicts every destination word, and a monitor compares each word as it
// leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ROWS          = psrm_pkg::MAX_ROWS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;

    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         cfg_wr_en    = 1'b0;
    logic                         cfg_wr_data  = 1'b0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [psrm_pkg::PIVOT_W-1:0] s_pivot_row  = '0;
    logic                         s_last_entry = 1'b0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [psrm_pkg::DEST_W-1:0]  m_dest_row;
    logic                         m_bad_pivot;
    logic                         m_last_result;

    int unsigned cycles        = 0;
    int unsigned mismatches    = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;

    logic                         walk_descending = 1'b0;
    logic [psrm_pkg::PIVOT_W-1:0] held_pivots [ROWS];
    int unsigned                  held_count = 0;
    int unsigned                  vector_buf [$];
    psrm_pkg::result_t            pending_moves [$];
    psrm_pkg::result_t            want_move;

    pivot_swaps_to_row_moves #(
        .MAX_ROWS(ROWS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pivot_row  (s_pivot_row),
        .s_last_entry (s_last_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest_row   (m_dest_row),
        .m_bad_pivot  (m_bad_pivot),
        .m_last_result(m_last_result)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Replays the held swaps over an unset map and queues one destination word per row.
    task automatic convert_pivots();
        int unsigned       dest_map [ROWS];
        bit                row_set [ROWS];
        bit                fault;
        int unsigned       k;
        int unsigned       i;
        int unsigned       t;
        int unsigned       cur_i;
        int unsigned       cur_t;
        psrm_pkg::result_t move;
        fault = 1'b0;
        for (k = 0; k < ROWS; k++) begin
            row_set[k]  = 1'b0;
            dest_map[k] = 0;
        end
        for (k = 0; k < held_count; k++) begin
            i = walk_descending ? held_count - 1 - k : k;
            if (held_pivots[i] == 0 || held_pivots[i] > held_count) begin
                fault = 1'b1;
                t     = i;
            end else begin
                t = held_pivots[i] - 1;
            end
            cur_i       = row_set[i] ? dest_map[i] : i;
            cur_t       = row_set[t] ? dest_map[t] : t;
            dest_map[i] = cur_t;
            row_set[i]  = 1'b1;
            if (t > i) begin
                dest_map[t] = cur_i;
                row_set[t]  = 1'b1;
            end
        end
        for (k = 0; k < held_count; k++) begin
            move.dest_row    = psrm_pkg::DEST_W'(row_set[k] ? dest_map[k] : k);
            move.bad_pivot   = fault;
            move.last_result = (k + 1 == held_count);
            pending_moves.push_back(move);
        end
        held_count = 0;
    endtask

    task automatic send_word(input int unsigned pivot, input bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pivot_row  <= psrm_pkg::PIVOT_W'(pivot);
        s_last_entry <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (held_count < ROWS) begin
            held_pivots[held_count] = psrm_pkg::PIVOT_W'(pivot);
            held_count++;
        end
        if (last) begin
            convert_pivots();
        end
    endtask

    task automatic send_vector();
        int unsigned k;
        for (k = 0; k < vector_buf.size(); k++) begin
            send_word(vector_buf[k], k + 1 == vector_buf.size());
        end
    endtask

    // The sender holds off until every destination word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_transpose(input bit descending);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= descending;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        walk_descending = descending;
    endtask

    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        set_transpose(1'b0);
        vector_buf = '{1};
        send_vector();
        vector_buf = '{0};
        send_vector();
        vector_buf = '{2, 2};
        send_vector();
        vector_buf = '{3, 127, 3};
        send_vector();
        set_transpose(1'b1);
        vector_buf = '{4, 3, 3, 4};
        send_vector();
        vector_buf = '{2, 1};
        send_vector();
        vector_buf = '{5, 0, 4, 5, 5};
        send_vector();
    endtask

    task automatic test_full_store();
        int unsigned k;
        src_idle_pct  = 32;
        snk_stall_pct = 32;
        set_transpose(1'b0);
        vector_buf = {};
        vector_buf.push_back(ROWS);
        for (k = 1; k < ROWS; k++) begin
            vector_buf.push_back($urandom_range(ROWS, k + 1));
        end
        send_vector();
        // The last three words overflow the store, and the final one starts conversion.
        set_transpose(1'b1);
        vector_buf = {};
        for (k = 0; k < ROWS; k++) begin
            vector_buf.push_back($urandom_range(ROWS, 1));
        end
        vector_buf.push_back(127);
        vector_buf.push_back(ROWS);
        vector_buf.push_back(0);
        send_vector();
    endtask

    task automatic test_random(input int unsigned n, input int unsigned src,
                               input int unsigned snk, input bit descending);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        int unsigned k;
        src_idle_pct  = src;
        snk_stall_pct = snk;
        set_transpose(descending);
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            vector_buf = {};
            for (k = 0; k < len; k++) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    vector_buf.push_back($urandom_range(len, k + 1));
                end else if (pick < 85) begin
                    vector_buf.push_back($urandom_range(len, 1));
                end else begin
                    vector_buf.push_back($urandom_range(127, 0));
                end
            end
            send_vector();
            sent += len;
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s mismatch: expected %0d, got %0d", field, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_moves.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected destination word: dest_row %0d", m_dest_row);
                end
            end else begin
                want_move = pending_moves.pop_front();
                compare_field("dest_row", want_move.dest_row, m_dest_row);
                compare_field("bad_pivot", want_move.bad_pivot, m_bad_pivot);
                compare_field("last_result", want_move.last_result, m_last_result);
            end
        end
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_store();
        test_random(70, 0, 0, 1'b1);
        test_random(70, 68, 0, 1'b0);
        test_random(70, 0, 68, 1'b1);
        test_random(70, 32, 32, 1'b0);
        drain();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
